// ===== hw/rtl/gab_pkg.sv =====
// Shared types, register indexes and arithmetic helpers for the glyph alpha blender.
// No dependencies; imported by all other files of the block.
package gab_pkg;

    localparam int GAB_MAX_CANVAS_SIDE = 512;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR    = 2'd2;

    localparam logic [9:0]  RST_CANVAS_WIDTH  = 10'd320;
    localparam logic [9:0]  RST_CANVAS_HEIGHT = 10'd240;
    localparam logic [15:0] RST_TEXT_COLOR    = 16'hFFFF;

    localparam logic [3:0] BPP_1 = 4'd1;
    localparam logic [3:0] BPP_2 = 4'd2;
    localparam logic [3:0] BPP_4 = 4'd4;
    localparam logic [3:0] BPP_8 = 4'd8;

    typedef struct packed {
        logic [11:0] glyph_origin_x;
        logic [11:0] glyph_origin_y;
        logic [7:0]  column;
        logic [7:0]  row;
        logic [7:0]  box_width;
        logic [7:0]  row_stride;
        logic [3:0]  bits_per_pixel;
        logic [7:0]  bitmap_byte;
        logic [15:0] background_pixel;
    } pix_t;

    typedef struct packed {
        logic [15:0] blended_pixel;
        logic        write_enable;
        logic [17:0] pixel_index;
        logic [16:0] sample_byte_offset;
    } res_t;

    // exact x / 255 for x below 16320, where the quotient fits six bits
    function automatic logic [5:0] div255(input logic [14:0] x);
        logic [15:0] t;
        t = 16'(x) + 16'd1 + 16'(x[14:8]);
        return t[13:8];
    endfunction

endpackage

// ===== hw/rtl/glyph_alpha_blend_pixel.sv =====
// Glyph pixel placer and RGB565 alpha blender, top level.
// Depends on gab_pkg and gab_blend.
// Registers in order: input, address, result; res_valid marks an item in the result register.
// One item per cycle while res_stall allows; address stage holds two 8x8 and one 10x10 multiply.
// Reset: pipeline empties, canvas returns to 320x240, text color to white.
module glyph_alpha_blend_pixel import gab_pkg::*;
#(
    parameter int MAX_CANVAS_SIDE = GAB_MAX_CANVAS_SIDE
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pix_valid,
    output logic                 pix_stall,
    input  pix_t                 pix,
    output logic                 res_valid,
    input  logic                 res_stall,
    output res_t                 res,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    typedef struct packed {
        logic [7:0]  alpha;
        logic [16:0] offset;
        logic        on_canvas;
        logic [17:0] index;
        logic [15:0] bg;
    } stage_t;

    logic [9:0]  canvas_width_reg;
    logic [9:0]  canvas_height_reg;
    logic [15:0] text_color_reg;

    logic   s1_valid_reg;
    pix_t   s1_reg;
    logic   s2_valid_reg;
    stage_t s2_reg;
    stage_t s2_next;
    logic   res_valid_reg;
    res_t   res_reg;
    res_t   res_next;

    logic adv_res;
    logic adv_s2;
    logic adv_s1;

    logic [9:0]  cw;
    logic [9:0]  ch;
    logic        bpp_ok;
    logic [1:0]  lg;
    logic [15:0] stride_prod;
    logic [16:0] packed_sum;
    logic [19:0] bit_pos;
    logic [7:0]  shifted;
    logic [12:0] tx;
    logic [12:0] ty;
    logic [19:0] idx_full;
    logic [15:0] blended;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= RST_CANVAS_WIDTH;
            canvas_height_reg <= RST_CANVAS_HEIGHT;
            text_color_reg    <= RST_TEXT_COLOR;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CANVAS_WIDTH:  canvas_width_reg  <= cfg_data[9:0];
                CFG_CANVAS_HEIGHT: canvas_height_reg <= cfg_data[9:0];
                CFG_TEXT_COLOR:    text_color_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign adv_res   = !res_valid_reg || !res_stall;
    assign adv_s2    = !s2_valid_reg || adv_res;
    assign adv_s1    = !s1_valid_reg || adv_s2;
    assign pix_stall = !adv_s1;

    always_comb
    begin
        cw = (32'(canvas_width_reg) > MAX_CANVAS_SIDE) ? 10'(MAX_CANVAS_SIDE)
                                                       : canvas_width_reg;
        ch = (32'(canvas_height_reg) > MAX_CANVAS_SIDE) ? 10'(MAX_CANVAS_SIDE)
                                                        : canvas_height_reg;

        bpp_ok = 1'b1;
        unique case (s1_reg.bits_per_pixel)
            BPP_1:   lg = 2'd0;
            BPP_2:   lg = 2'd1;
            BPP_4:   lg = 2'd2;
            BPP_8:   lg = 2'd3;
            default:
            begin
                lg     = 2'd0;
                bpp_ok = 1'b0;
            end
        endcase

        stride_prod = s1_reg.row * s1_reg.row_stride;
        packed_sum  = 17'(s1_reg.row * s1_reg.box_width) + 17'(s1_reg.column);
        if (s1_reg.row_stride != 8'd0)
            bit_pos = {1'b0, stride_prod, 3'b000} + (20'(s1_reg.column) << lg);
        else
            bit_pos = 20'(packed_sum) << lg;

        // sample is the top bpp bits once the in-byte offset is shifted out
        shifted = s1_reg.bitmap_byte << bit_pos[2:0];
        unique case (lg)
            2'd0: s2_next.alpha = {8{shifted[7]}};
            2'd1: s2_next.alpha = 8'(shifted[7:6] * 8'd85);
            2'd2: s2_next.alpha = 8'(shifted[7:4] * 8'd17);
            2'd3: s2_next.alpha = shifted;
            default: s2_next.alpha = 8'd0;
        endcase
        if (!bpp_ok)
            s2_next.alpha = 8'd0;
        s2_next.offset = bpp_ok ? bit_pos[19:3] : 17'd0;

        tx = {s1_reg.glyph_origin_x[11], s1_reg.glyph_origin_x} + {5'd0, s1_reg.column};
        ty = {s1_reg.glyph_origin_y[11], s1_reg.glyph_origin_y} + {5'd0, s1_reg.row};
        s2_next.on_canvas = !tx[12] && !ty[12] && (tx[11:0] < 12'(cw))
                            && (ty[11:0] < 12'(ch));
        idx_full = 20'(ty[9:0]) * 20'(cw) + 20'(tx[9:0]);
        s2_next.index = s2_next.on_canvas ? idx_full[17:0] : 18'd0;
        s2_next.bg    = s1_reg.background_pixel;
    end

    gab_blend u_blend
    (
        .alpha (s2_reg.alpha),
        .fg    (text_color_reg),
        .bg    (s2_reg.bg),
        .pixel (blended)
    );

    always_comb
    begin
        res_next.blended_pixel      = blended;
        res_next.write_enable       = s2_reg.on_canvas && (s2_reg.alpha != 8'd0);
        res_next.pixel_index        = s2_reg.index;
        res_next.sample_byte_offset = s2_reg.offset;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_s1)
                s1_valid_reg <= pix_valid;
            if (adv_s2)
                s2_valid_reg <= s1_valid_reg;
            if (adv_res)
                res_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_s1 && pix_valid)
            s1_reg <= pix;
        if (adv_s2 && s1_valid_reg)
            s2_reg <= s2_next;
        if (adv_res && s2_valid_reg)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== hw/rtl/gab_blend.sv =====
// RGB565 per-channel alpha blend with rounding.
// Depends on gab_pkg (div255).
module gab_blend import gab_pkg::*;
(
    input  logic [7:0]  alpha,
    input  logic [15:0] fg,
    input  logic [15:0] bg,
    output logic [15:0] pixel
);

    logic [7:0]  inv;
    logic [14:0] sum_r;
    logic [14:0] sum_g;
    logic [14:0] sum_b;
    logic [5:0]  q_r;
    logic [5:0]  q_g;
    logic [5:0]  q_b;

    always_comb
    begin
        inv   = 8'd255 - alpha;
        sum_r = 15'(fg[15:11] * alpha) + 15'(bg[15:11] * inv) + 15'd127;
        sum_g = 15'(fg[10:5] * alpha) + 15'(bg[10:5] * inv) + 15'd127;
        sum_b = 15'(fg[4:0] * alpha) + 15'(bg[4:0] * inv) + 15'd127;
        q_r   = div255(sum_r);
        q_g   = div255(sum_g);
        q_b   = div255(sum_b);
        pixel = {q_r[4:0], q_g, q_b[4:0]};
    end

endmodule

// ===== hw/rtl/gab_check.sv =====
// Port-level checker for glyph_alpha_blend_pixel, with its bind.
// Depends on gab_pkg (res_t).
module gab_check import gab_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic pix_stall,
    input logic res_valid,
    input logic res_stall,
    input res_t res,
    input logic cfg_ready
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result item changed");

    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> !pix_stall)
        else $error("input stalled with empty output");

    a_flow_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !res_stall |-> !pix_stall)
        else $error("input stalled while output drains");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind glyph_alpha_blend_pixel gab_check u_gab_check
(
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_stall (pix_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_ready (cfg_ready)
);
